// ----- sv/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// shared command codes, phase layout constants and types of the i2c master
// byte engine
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam logic [2:0] CMD_IDLE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ_ACK = 3'd4;
    localparam logic [2:0] CMD_READ_NAK = 3'd5;

    localparam logic [1:0] SMP_NONE = 2'd0;
    localparam logic [1:0] SMP_ACK  = 2'd1;
    localparam logic [1:0] SMP_BIT  = 2'd2;

    localparam logic [4:0] PHASES_COND  = 5'd3;
    localparam logic [4:0] PHASES_WRITE = 5'd27;
    localparam logic [4:0] PHASES_READ  = 5'd20;

    localparam logic [4:0] WR_DATA_END  = 5'd24;
    localparam logic [4:0] WR_ACK_HIGH  = 5'd25;
    localparam logic [4:0] WR_ACK_LOW   = 5'd26;
    localparam logic [4:0] RD_BITS_END  = 5'd16;
    localparam logic [4:0] RD_ACK_HIGH  = 5'd18;
    localparam logic [4:0] RD_ACK_LOW   = 5'd19;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [1:0] smp;
    } drive_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
    } result_t;

    function automatic logic [4:0] phase_count(input logic [2:0] cmd);
        logic [4:0] n;
        case (cmd)
            CMD_START, CMD_STOP: n = PHASES_COND;
            CMD_WRITE:           n = PHASES_WRITE;
            default:             n = PHASES_READ;
        endcase
        return n;
    endfunction

endpackage

// ----- sv/i2cmbe_ifs.sv -----
// ----------------------------------------------------------------------------
// i2cmbe request and response channels
// valid/ready channels carrying one tick item in and one tick result out
// ----------------------------------------------------------------------------
interface i2cmbe_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] write_byte;
    logic       sda_in;

    modport source (output valid, output action, output write_byte, output sda_in,
                    input ready);
    modport sink (input valid, input action, input write_byte, input sda_in,
                  output ready);
endinterface

interface i2cmbe_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;

    modport source (output valid, output scl_out, output sda_release, output busy_res,
                    output done_res, output read_byte, output ack_seen, input ready);
    modport sink (input valid, input scl_out, input sda_release, input busy_res,
                  input done_res, input read_byte, input ack_seen, output ready);
endinterface

// ----- sv/i2c_master_byte_engine_top.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// response: a result is registered and valid in the cycle after its transaction is accepted
// throughput: one transaction per cycle while the response side is ready, set by the single-step sequencer
// reset: asynchronous active low; idle, scl and sda released, phase_ticks 50
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top
#(
    parameter int TICK_WIDTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    i2cmbe_req_if.sink    req,
    i2cmbe_rsp_if.source  rsp
);
    import i2cmbe_pkg::*;

    logic [15:0] phase_ticks_reg;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    result_t     res;

    assign req.ready = ~out_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                phase_ticks_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    i2cmbe_sequencer #(.TICK_WIDTH(TICK_WIDTH)) u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .phase_ticks (phase_ticks_reg),
        .action      (req.action),
        .write_byte  (req.write_byte),
        .sda_in      (req.sda_in),
        .res         (res)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.scl_out     = res.scl_out;
    assign rsp.sda_release = res.sda_release;
    assign rsp.busy_res    = res.busy_res;
    assign rsp.done_res    = res.done_res;
    assign rsp.read_byte   = res.read_byte;
    assign rsp.ack_seen    = res.ack_seen;

endmodule

// ----- sv/i2cmbe_phase_decode.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_phase_decode
// bus levels and sampling kind of one phase of the active command
// ----------------------------------------------------------------------------
module i2cmbe_phase_decode
(
    input  logic [2:0]            cmd,
    input  logic [4:0]            idx,
    input  logic [7:0]            shift,
    input  logic                  scl_lvl,
    input  logic                  sda_lvl,
    output i2cmbe_pkg::drive_t    drv
);
    import i2cmbe_pkg::*;

    logic [8:0] prod;
    logic [2:0] bit_sel;
    logic [4:0] rem;

    // idx / 3 as a reciprocal multiply, exact for the data phases
    assign prod    = 9'(idx) * 9'd11;
    assign bit_sel = prod[7:5];
    assign rem     = idx - 5'({bit_sel, 1'b0}) - 5'(bit_sel);

    always_comb
    begin
        drv.scl = scl_lvl;
        drv.sda = sda_lvl;
        drv.smp = SMP_NONE;
        case (cmd)
            CMD_START:
            begin
                drv.scl = (idx < 5'd2);
                drv.sda = (idx == 5'd0);
            end
            CMD_STOP:
            begin
                drv.scl = (idx != 5'd0);
                drv.sda = (idx == 5'd2);
            end
            CMD_WRITE:
            begin
                if (idx < WR_DATA_END)
                begin
                    drv.sda = shift[3'd7 - bit_sel];
                    if (rem == 5'd1)
                    begin
                        drv.scl = 1'b1;
                    end
                    else if (rem == 5'd2)
                    begin
                        drv.scl = 1'b0;
                    end
                end
                else
                begin
                    drv.sda = 1'b1;
                    if (idx == WR_ACK_HIGH)
                    begin
                        drv.scl = 1'b1;
                        drv.smp = SMP_ACK;
                    end
                    else if (idx == WR_ACK_LOW)
                    begin
                        drv.scl = 1'b0;
                    end
                end
            end
            CMD_READ_ACK, CMD_READ_NAK:
            begin
                if (idx == 5'd0)
                begin
                    drv.sda = 1'b1;
                end
                else if (idx <= RD_BITS_END)
                begin
                    drv.sda = 1'b1;
                    if (idx[0])
                    begin
                        drv.scl = 1'b1;
                        drv.smp = SMP_BIT;
                    end
                    else
                    begin
                        drv.scl = 1'b0;
                    end
                end
                else
                begin
                    drv.sda = (cmd == CMD_READ_NAK);
                    if (idx == RD_ACK_HIGH)
                    begin
                        drv.scl = 1'b1;
                    end
                    else if (idx == RD_ACK_LOW)
                    begin
                        drv.scl = 1'b0;
                    end
                end
            end
            default:
            begin
                drv.smp = SMP_NONE;
            end
        endcase
    end

endmodule

// ----- sv/i2cmbe_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_sequencer
// command, phase and tick state; one step per accepted transaction with the
// result held in registers
// ----------------------------------------------------------------------------
module i2cmbe_sequencer
#(
    parameter int TICK_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [15:0]           phase_ticks,
    input  logic [2:0]            action,
    input  logic [7:0]            write_byte,
    input  logic                  sda_in,
    output i2cmbe_pkg::result_t   res
);
    import i2cmbe_pkg::*;

    localparam int CW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    logic [2:0]            cmd_reg,   cmd_next,   cmd_cur;
    logic [4:0]            idx_reg,   idx_next,   idx_cur, idx_inc;
    logic [TICK_WIDTH-1:0] tick_reg,  tick_next,  tick_cur;
    logic [7:0]            shift_reg, shift_next, shift_cur;
    logic                  ack_reg,   ack_next;
    logic                  scl_reg,   scl_next;
    logic                  sda_reg,   sda_next;
    logic [7:0]            rd_reg,    rd_next;
    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;

    logic [TICK_WIDTH-1:0] tick_max;
    logic [CW-1:0]         pt_ext;
    logic [TICK_WIDTH-1:0] limit;
    logic                  last;
    drive_t                drv;

    assign tick_max = '1;
    assign pt_ext   = CW'(phase_ticks);

    always_comb
    begin
        if (pt_ext == '0)
        begin
            limit = TICK_WIDTH'(1);
        end
        else if (pt_ext > CW'(tick_max))
        begin
            limit = tick_max;
        end
        else
        begin
            limit = pt_ext[TICK_WIDTH-1:0];
        end
    end

    always_comb
    begin
        cmd_cur   = cmd_reg;
        idx_cur   = idx_reg;
        tick_cur  = tick_reg;
        shift_cur = shift_reg;
        if (cmd_reg == CMD_IDLE && (action inside {[CMD_START:CMD_READ_NAK]}))
        begin
            cmd_cur   = action;
            idx_cur   = '0;
            tick_cur  = '0;
            shift_cur = (action == CMD_WRITE) ? write_byte : 8'd0;
        end
    end

    i2cmbe_phase_decode u_decode
    (
        .cmd     (cmd_cur),
        .idx     (idx_cur),
        .shift   (shift_cur),
        .scl_lvl (scl_reg),
        .sda_lvl (sda_reg),
        .drv     (drv)
    );

    assign last    = (tick_cur >= (limit - TICK_WIDTH'(1)));
    assign idx_inc = idx_cur + 5'd1;

    always_comb
    begin
        cmd_next   = cmd_cur;
        idx_next   = idx_cur;
        tick_next  = tick_cur;
        shift_next = shift_cur;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rd_next    = rd_reg;
        busy_next  = 1'b0;
        done_next  = 1'b0;
        if (cmd_cur != CMD_IDLE)
        begin
            busy_next = 1'b1;
            scl_next  = drv.scl;
            sda_next  = drv.sda;
            if (drv.smp == SMP_ACK && tick_cur == '0)
            begin
                ack_next = ~sda_in;
            end
            if (drv.smp == SMP_BIT && last)
            begin
                shift_next = {shift_cur[6:0], sda_in};
            end
            if (last)
            begin
                tick_next = '0;
                idx_next  = idx_inc;
                if (idx_inc >= phase_count(cmd_cur))
                begin
                    done_next = 1'b1;
                    if (cmd_cur == CMD_READ_ACK || cmd_cur == CMD_READ_NAK)
                    begin
                        rd_next = shift_next;
                    end
                    cmd_next = CMD_IDLE;
                    idx_next = '0;
                end
            end
            else
            begin
                tick_next = tick_cur + TICK_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            idx_reg   <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rd_reg    <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (step)
        begin
            cmd_reg   <= cmd_next;
            idx_reg   <= idx_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rd_reg    <= rd_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign res.scl_out     = scl_reg;
    assign res.sda_release = sda_reg;
    assign res.busy_res    = busy_reg;
    assign res.done_res    = done_reg;
    assign res.read_byte   = rd_reg;
    assign res.ack_seen    = ack_reg;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: i2c master byte engine testbench
// drives one bus tick per request transaction and predicts the scl/sda levels,
// busy/done flags, read byte and acknowledge flag of every response
// transaction. It runs directed start, stop, write and read sequences, then
// random well-formed and broken bus sequences under several phase lengths,
// with random gaps on the request side and stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cmbe_pkg::*;

    class i2c_bus_scoreboard;
        logic [15:0] phase_ticks;
        logic [2:0]  cmd;
        int          phase_idx;
        int          tick_cnt;
        logic [7:0]  shreg;
        logic        ack_flag;
        logic        scl_lvl;
        logic        sda_lvl;
        logic [7:0]  read_result;
        result_t     expected_ticks[$];
        int          errors;

        function new();
            phase_ticks = PHASE_TICKS_RESET;
            cmd         = CMD_IDLE;
            phase_idx   = 0;
            tick_cnt    = 0;
            shreg       = 8'h00;
            ack_flag    = 1'b0;
            scl_lvl     = 1'b1;
            sda_lvl     = 1'b1;
            read_result = 8'h00;
            errors      = 0;
        endfunction

        function bit busy();
            return cmd != CMD_IDLE;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // advances the bus sequencer by one tick and queues the expected levels
        function void note_tick(logic [2:0] action, logic [7:0] wbyte, logic sda);
            result_t    r;
            logic [1:0] smp;
            int         limit;
            int         nphases;
            bit         last;
            r = '0;
            if (cmd == CMD_IDLE && action >= CMD_START && action <= CMD_READ_NAK)
            begin
                cmd       = action;
                phase_idx = 0;
                tick_cnt  = 0;
                shreg     = (action == CMD_WRITE) ? wbyte : 8'h00;
            end
            if (cmd != CMD_IDLE)
            begin
                r.busy_res = 1'b1;
                smp = SMP_NONE;
                case (cmd)
                    CMD_START:
                    begin
                        scl_lvl = (phase_idx < 2);
                        sda_lvl = (phase_idx == 0);
                        nphases = PHASES_COND;
                    end
                    CMD_STOP:
                    begin
                        scl_lvl = (phase_idx != 0);
                        sda_lvl = (phase_idx == 2);
                        nphases = PHASES_COND;
                    end
                    CMD_WRITE:
                    begin
                        nphases = PHASES_WRITE;
                        if (phase_idx < WR_DATA_END)
                        begin
                            sda_lvl = shreg[7 - phase_idx / 3];
                            if (phase_idx % 3 == 1)
                                scl_lvl = 1'b1;
                            else if (phase_idx % 3 == 2)
                                scl_lvl = 1'b0;
                        end
                        else
                        begin
                            sda_lvl = 1'b1;
                            if (phase_idx == WR_ACK_HIGH)
                            begin
                                scl_lvl = 1'b1;
                                smp = SMP_ACK;
                            end
                            else if (phase_idx == WR_ACK_LOW)
                                scl_lvl = 1'b0;
                        end
                    end
                    default:
                    begin
                        nphases = PHASES_READ;
                        if (phase_idx == 0)
                            sda_lvl = 1'b1;
                        else if (phase_idx <= RD_BITS_END)
                        begin
                            sda_lvl = 1'b1;
                            if ((phase_idx - 1) % 2 == 0)
                            begin
                                scl_lvl = 1'b1;
                                smp = SMP_BIT;
                            end
                            else
                                scl_lvl = 1'b0;
                        end
                        else
                        begin
                            sda_lvl = (cmd == CMD_READ_NAK);
                            if (phase_idx == RD_ACK_HIGH)
                                scl_lvl = 1'b1;
                            else if (phase_idx == RD_ACK_LOW)
                                scl_lvl = 1'b0;
                        end
                    end
                endcase
                limit = (phase_ticks == 16'd0) ? 1 : int'(phase_ticks);
                if (smp == SMP_ACK && tick_cnt == 0)
                    ack_flag = ~sda;
                last = (tick_cnt + 1 >= limit);
                if (smp == SMP_BIT && last)
                    shreg = {shreg[6:0], sda};
                if (last)
                begin
                    tick_cnt = 0;
                    phase_idx++;
                    if (phase_idx >= nphases)
                    begin
                        r.done_res = 1'b1;
                        if (cmd == CMD_READ_ACK || cmd == CMD_READ_NAK)
                            read_result = shreg;
                        cmd = CMD_IDLE;
                        phase_idx = 0;
                    end
                end
                else
                    tick_cnt++;
            end
            r.scl_out     = scl_lvl;
            r.sda_release = sda_lvl;
            r.read_byte   = read_result;
            r.ack_seen    = ack_flag;
            expected_ticks.push_back(r);
        endfunction

        function void match_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_tick(result_t got);
            result_t want;
            if (expected_ticks.size() == 0)
            begin
                errors++;
                $display("%0t: response with no transaction pending, actual %0h", $time, got);
                return;
            end
            want = expected_ticks.pop_front();
            match_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
            match_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
            match_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            match_field("done_res", 8'(want.done_res), 8'(got.done_res));
            match_field("read_byte", want.read_byte, got.read_byte);
            match_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
        endfunction
    endclass

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_TICKS = 300;
    localparam int SDA_LOW      = 0;
    localparam int SDA_HIGH     = 1;
    localparam int SDA_RANDOM   = 2;
    localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        hold_request;
    int          burst_left;
    int          stall_cycles;
    result_t     rsp_seen;
    logic [2:0]  bus_plan[$];
    int unsigned phase_plan[7] = '{1, 2, 1, 3, 0, 1, 4};

    i2c_bus_scoreboard sb = new();

    i2cmbe_req_if req();
    i2cmbe_rsp_if rsp();

    i2c_master_byte_engine_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    assign rsp_seen = {rsp.scl_out, rsp.sda_release, rsp.busy_res, rsp.done_res,
                       rsp.read_byte, rsp.ack_seen};

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_tick(rsp_seen);
    end

    initial
    begin
        stall_cycles = 0;
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("FAIL i2c_master_byte_engine_top");
            $finish;
        end
    end

    // response side: rotating stall patterns, plus one long hold on request
    initial
    begin
        int cyc;
        rsp.ready = 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                case ((cyc / 64) % 4)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 1) == 1);
                    2: rsp.ready <= (cyc % 4 == 0);
                    default: rsp.ready <= ($urandom_range(0, 9) < 8);
                endcase
                cyc++;
            end
        end
    end

    function automatic logic pick_sda(int mode);
        if (mode == SDA_LOW)
            return 1'b0;
        if (mode == SDA_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_tick(logic [2:0] action, logic [7:0] wbyte, logic sda);
        int gap;
        @(negedge clk);
        req.valid      <= 1'b1;
        req.action     <= action;
        req.write_byte <= wbyte;
        req.sda_in     <= sda;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_tick(action, wbyte, sda);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                gap = $urandom_range(1, 8);
                repeat (gap)
                begin
                    @(negedge clk);
                    req.valid <= 1'b0;
                end
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic write_phase_ticks(logic [15:0] value);
        wait_drained();
        repeat (2) @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.phase_ticks = value;
    endtask

    task automatic run_command(logic [2:0] action, logic [7:0] wbyte, int sda_mode,
                               logic [2:0] busy_act);
        send_tick(action, wbyte, pick_sda(sda_mode));
        while (sb.busy())
            send_tick(busy_act, 8'($urandom_range(0, 255)), pick_sda(sda_mode));
    endtask

    task automatic random_tick();
        logic [2:0] act;
        int         nreads;
        if (!sb.busy() && $urandom_range(0, 99) < 75)
        begin
            if (bus_plan.size() == 0)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    bus_plan.push_back(CMD_START);
                    repeat ($urandom_range(1, 3)) bus_plan.push_back(CMD_WRITE);
                    nreads = $urandom_range(0, 3);
                    for (int k = 0; k < nreads; k++)
                        bus_plan.push_back((k == nreads - 1) ? CMD_READ_NAK : CMD_READ_ACK);
                    bus_plan.push_back(CMD_STOP);
                end
                else
                    bus_plan.push_back(3'($urandom_range(CMD_START, CMD_READ_NAK)));
            end
            act = bus_plan.pop_front();
        end
        else if (sb.busy() && $urandom_range(0, 99) < 85)
            act = CMD_IDLE;
        else
            act = 3'($urandom_range(0, 7));
        send_tick(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        req.valid      = 1'b0;
        req.action     = CMD_IDLE;
        req.write_byte = 8'h00;
        req.sda_in     = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 16'h0000;
        hold_request   = 1'b0;
        burst_left     = 0;
        rst_n          = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset phase length
        run_command(CMD_START, 8'h00, SDA_HIGH, CMD_IDLE);

        write_phase_ticks(16'd1);
        run_command(CMD_START, 8'h00, SDA_HIGH, CMD_IDLE);
        run_command(CMD_WRITE, 8'hFF, SDA_HIGH, CMD_IDLE);
        run_command(CMD_WRITE, 8'h00, SDA_LOW, CMD_IDLE);
        run_command(CMD_WRITE, 8'hA5, SDA_RANDOM, CMD_STOP);
        run_command(CMD_READ_ACK, 8'h00, SDA_HIGH, CMD_IDLE);
        run_command(CMD_READ_NAK, 8'hFF, SDA_LOW, CMD_IDLE);
        run_command(CMD_READ_ACK, 8'h3C, SDA_RANDOM, CMD_WRITE);
        run_command(ACT_UNUSED_6, 8'hFF, SDA_HIGH, CMD_IDLE);
        run_command(ACT_UNUSED_7, 8'h00, SDA_LOW, CMD_IDLE);
        run_command(CMD_IDLE, 8'hFF, SDA_RANDOM, CMD_IDLE);
        run_command(CMD_STOP, 8'h00, SDA_RANDOM, CMD_IDLE);

        // zero phase length is treated as a phase length of one
        write_phase_ticks(16'd0);
        run_command(CMD_START, 8'h00, SDA_RANDOM, CMD_IDLE);
        run_command(CMD_WRITE, 8'h5A, SDA_RANDOM, CMD_IDLE);
        run_command(CMD_READ_NAK, 8'h00, SDA_RANDOM, CMD_IDLE);
        run_command(CMD_STOP, 8'h00, SDA_RANDOM, CMD_IDLE);

        // longest phase, shortened partway through the start condition
        write_phase_ticks(16'hFFFF);
        send_tick(CMD_START, 8'h00, 1'b1);
        repeat (40) send_tick(CMD_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        write_phase_ticks(16'd3);
        while (sb.busy())
            send_tick(CMD_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        for (int n = 0; n < RANDOM_TICKS; n++)
        begin
            if (n % 50 == 0)
                write_phase_ticks(16'(phase_plan[n / 50]));
            if (n == 150)
                hold_request = 1'b1;
            if (n == 220)
                wait_drained();
            random_tick();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS i2c_master_byte_engine_top");
        else
            $display("FAIL i2c_master_byte_engine_top");
        $finish;
    end

endmodule
